### rtl/hex_rgb_to_led_pulse_encoder_assert.svh
// assertion macros for the hex rgb to led pulse encoder
`ifndef HEX_RGB_TO_LED_PULSE_ENCODER_ASSERT_SVH
`define HEX_RGB_TO_LED_PULSE_ENCODER_ASSERT_SVH

// checked only while out of reset
`define HRLPE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// checked on every edge, reset included
`define HRLPE_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

### rtl/hrlpe_pkg.sv
// shared constants, types and helpers of the hex rgb to led pulse encoder
package hrlpe_pkg;

    localparam int LEDS_PER_FRAME = 40;
    localparam int LED_CNT_W      = (LEDS_PER_FRAME > 1) ? $clog2(LEDS_PER_FRAME) : 1;
    localparam int LED_IDX_W      = 6;
    localparam int CHAR_W         = 8;
    localparam int CMP_W          = 16;
    localparam int PERIOD_W       = 16;
    localparam int GRB_W          = 24;
    localparam int BEAT_CNT_W     = $clog2(GRB_W + 1);
    localparam int M_DATA_W       = ((CMP_W + LED_IDX_W + 7) / 8) * 8;
    localparam int M_PAD_W        = M_DATA_W - CMP_W - LED_IDX_W;
    localparam int S_DATA_W       = CHAR_W;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd39;

    // floor(num * x / 100) as (x * ceil(num * 2^24 / 100)) >> 24, exact for 16-bit x
    localparam int RECIP_SHIFT = 24;
    localparam int RECIP_W     = 24;
    localparam logic [RECIP_W-1:0] RECIP_ONE  = RECIP_W'((66 * (64'd1 << RECIP_SHIFT) + 99) / 100);
    localparam logic [RECIP_W-1:0] RECIP_ZERO = RECIP_W'((33 * (64'd1 << RECIP_SHIFT) + 99) / 100);

    // positions within the six-character group
    localparam logic [2:0] POS_LAST = 3'd5;
    localparam logic [2:0] POS_P1   = 3'd1;
    localparam logic [2:0] POS_P2   = 3'd3;

    localparam logic [CHAR_W-1:0] ASCII_0 = 8'h30;
    localparam logic [CHAR_W-1:0] ASCII_A = 8'h41;
    localparam logic [CHAR_W-1:0] HEX_A_OFS = 8'h37;  // 'A' - 10

    typedef struct packed {
        logic                 valid;
        logic [GRB_W-1:0]     grb;
        logic [LED_IDX_W-1:0] led;
    } hrlpe_group_t;

    function automatic logic [PERIOD_W-1:0] period_span(input logic [PERIOD_W-1:0] period);
        period_span = (period == '0) ? '0 : period - 1'b1;
    endfunction

    function automatic logic [CMP_W-1:0] scale_span(input logic [PERIOD_W-1:0] span,
                                                    input logic [RECIP_W-1:0]  recip);
        logic [PERIOD_W+RECIP_W-1:0] prod;
        prod       = PERIOD_W'(span) * recip;
        scale_span = CMP_W'(prod >> RECIP_SHIFT);
    endfunction

endpackage

### rtl/hex_rgb_to_led_pulse_encoder.sv
// top level of the hex rgb to led pulse encoder
//
// s_ channel: one ascii hex character per beat in s_tdata[7:0], six per led,
// text order red, green, blue. m_ channel: one pwm compare value per beat,
// 24 beats per led, msb first in green, red, blue order; m_tdata[15:0] is
// the compare value, m_tdata[21:16] the led index in the frame, m_tlast
// marks the 24th beat of an led. cfg channel writes the timer period; the
// two compare values are worked out from it in the write cycle itself.
// latency: the first beat of an led is valid the cycle after its sixth
// character is taken. throughput: one result beat per cycle while the
// receiver is ready; the first five characters of a group are taken in any
// cycle. a sixth character waits until the previous led's last beat leaves,
// so a stalled receiver holds back the input after at most five more
// characters. reset clears the group position, led counter and serializer
// and brings the period back to 39.
module hex_rgb_to_led_pulse_encoder
    import hrlpe_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // [7:0] hex_char
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // [15:0] compare_value, [21:16] led_index
    output logic                m_tlast,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [PERIOD_W-1:0] cfg_data   // timer_period
);

    hrlpe_group_t      group;
    logic              load_ok;
    logic [CMP_W-1:0]  one_reg, zero_reg;
    logic [PERIOD_W-1:0] cfg_span;
    logic [LED_IDX_W-1:0] m_led;

    assign cfg_ready = 1'b1;
    assign cfg_span  = period_span(cfg_data);
    assign m_led     = m_tdata[CMP_W +: LED_IDX_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            one_reg  <= scale_span(period_span(PERIOD_RESET), RECIP_ONE);
            zero_reg <= scale_span(period_span(PERIOD_RESET), RECIP_ZERO);
        end else if (cfg_valid) begin
            one_reg  <= scale_span(cfg_span, RECIP_ONE);
            zero_reg <= scale_span(cfg_span, RECIP_ZERO);
        end
    end

    hrlpe_decode u_decode (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .load_ok  (load_ok),
        .group    (group)
    );

    hrlpe_emit u_emit (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .group    (group),
        .one_val  (one_reg),
        .zero_val (zero_reg),
        .load_ok  (load_ok),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

`include "hex_rgb_to_led_pulse_encoder_assert.svh"

    // a new led may only load when the serializer is empty or on its last beat
    `HRLPE_ASSERT(a_no_overrun, group.valid |-> (!m_tvalid || (m_tlast && m_tready)), "overrun")

    // the serializer is empty right after reset
    `HRLPE_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !m_tvalid, "beat valid after reset")

    // led index stays inside the frame
    `HRLPE_ASSERT(a_led_range, m_tvalid |-> (m_led < LED_IDX_W'(LEDS_PER_FRAME)), "led out of frame")

endmodule

### rtl/hrlpe_decode.sv
// character decoder and six-character group assembler
module hrlpe_decode
    import hrlpe_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // [7:0] hex_char
    input  logic                load_ok,
    output hrlpe_group_t        group
);

    logic [2:0]           pos_reg, pos_next;
    logic [3:0]           nibble_reg;
    logic [7:0]           p1_reg, p2_reg;
    logic [LED_CNT_W-1:0] led_reg, led_next;
    logic [7:0]           digit;
    logic [7:0]           pair_byte;
    logic                 accept;
    logic                 is_last;

    assign is_last  = (pos_reg == POS_LAST);
    assign s_tready = !is_last || load_ok;
    assign accept   = s_tvalid && s_tready;

    // non-hex characters follow the same rule with wrapping
    assign digit     = (s_tdata < ASCII_A) ? s_tdata - ASCII_0 : s_tdata - HEX_A_OFS;
    assign pair_byte = {nibble_reg, 4'b0000} + digit;

    always_comb begin
        pos_next = pos_reg;
        led_next = led_reg;
        if (accept) begin
            if (is_last) begin
                pos_next = '0;
                led_next = (led_reg == LED_CNT_W'(LEDS_PER_FRAME - 1)) ? '0 : led_reg + 1'b1;
            end else begin
                pos_next = pos_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
            led_reg <= '0;
        end else begin
            pos_reg <= pos_next;
            led_reg <= led_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            if (!pos_reg[0]) begin
                nibble_reg <= digit[3:0];
            end
            if (pos_reg == POS_P1) begin
                p1_reg <= pair_byte;
            end
            if (pos_reg == POS_P2) begin
                p2_reg <= pair_byte;
            end
        end
    end

    // green, red, blue on the wire
    assign group.valid = accept && is_last;
    assign group.grb   = {p2_reg, p1_reg, pair_byte};
    assign group.led   = LED_IDX_W'(led_reg);

endmodule

### rtl/hrlpe_emit.sv
// bit serializer that turns one led's 24 color bits into compare value beats
module hrlpe_emit
    import hrlpe_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  hrlpe_group_t        group,
    input  logic [CMP_W-1:0]    one_val,
    input  logic [CMP_W-1:0]    zero_val,
    output logic                load_ok,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // [15:0] compare_value, [21:16] led_index
    output logic                m_tlast
);

    logic [BEAT_CNT_W-1:0] left_reg, left_next;
    logic [GRB_W-1:0]      bits_reg, bits_next;
    logic [LED_IDX_W-1:0]  led_reg;
    logic                  take;

    assign m_tvalid = (left_reg != '0);
    assign m_tlast  = (left_reg == BEAT_CNT_W'(1));
    assign take     = m_tvalid && m_tready;
    assign load_ok  = !m_tvalid || (m_tlast && m_tready);

    always_comb begin
        left_next = left_reg;
        bits_next = bits_reg;
        if (group.valid) begin
            left_next = BEAT_CNT_W'(GRB_W);
            bits_next = group.grb;
        end else if (take) begin
            left_next = left_reg - 1'b1;
            bits_next = {bits_reg[GRB_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_reg <= '0;
        end else begin
            left_reg <= left_next;
        end
    end

    always_ff @(posedge aclk) begin
        bits_reg <= bits_next;
        if (group.valid) begin
            led_reg <= group.led;
        end
    end

    assign m_tdata = {{M_PAD_W{1'b0}}, led_reg, bits_reg[GRB_W-1] ? one_val : zero_val};

endmodule

### sim/hex_rgb_to_led_pulse_encoder_tb.sv
// testbench for the hex rgb to led pulse encoder: character stream in, per-bit compare values out
module hex_rgb_to_led_pulse_encoder_tb
    import hrlpe_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam int ITEMS_PER_PHASE = 67;
    localparam int ONE_DUTY_PCT  = 66;
    localparam int ZERO_DUTY_PCT = 33;

    typedef struct {
        logic [CMP_W-1:0]     compare_value;
        logic [LED_IDX_W-1:0] led_index;
        logic                 last;
    } bit_slot_t;

    typedef enum int {
        READY_ALWAYS,
        READY_RANDOM,
        READY_ONE_IN_FOUR,
        READY_SPARSE
    } stall_mode_t;

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata   = '0;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tlast;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [PERIOD_W-1:0] cfg_data  = '0;

    // pending characters and the compare values they are expected to produce
    logic [CHAR_W-1:0] char_q[$];
    bit_slot_t         bit_slot_q[$];

    // predictor state
    logic [PERIOD_W-1:0] timer_period = PERIOD_RESET;
    logic [2:0]          group_pos    = '0;
    logic [3:0]          high_nibble  = '0;
    logic [7:0]          red_byte     = '0;
    logic [7:0]          green_byte   = '0;
    int                  led_count    = 0;

    int          mismatches  = 0;
    int          cycle_count = 0;
    int          burst_left  = 1;
    int          gap_left    = 0;
    int          stall_tick  = 0;
    stall_mode_t stall_mode  = READY_ALWAYS;

    string hex_text = "0123456789ABCDEF";

    hex_rgb_to_led_pulse_encoder i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #10 aclk = ~aclk;

    function automatic logic [7:0] hex_digit(input logic [CHAR_W-1:0] c);
        // non-hex characters wrap the same way; only the low four bits are kept for a high nibble
        return (c < ASCII_A) ? c - ASCII_0 : c - HEX_A_OFS;
    endfunction

    task automatic encode_char(input logic [CHAR_W-1:0] c);
        logic [7:0]          digit;
        logic [7:0]          pair_byte;
        logic [GRB_W-1:0]    grb;
        logic [PERIOD_W-1:0] span;
        int                  one_cmp;
        int                  zero_cmp;
        bit_slot_t           slot;
        digit = hex_digit(c);
        if (!group_pos[0]) begin
            high_nibble = digit[3:0];
            group_pos   = group_pos + 3'd1;
        end else begin
            pair_byte = {high_nibble, 4'h0} + digit;
            if (group_pos == POS_P1) begin
                red_byte  = pair_byte;
                group_pos = group_pos + 3'd1;
            end else if (group_pos == POS_P2) begin
                green_byte = pair_byte;
                group_pos  = group_pos + 3'd1;
            end else begin
                span     = (timer_period == '0) ? '0 : timer_period - 16'd1;
                one_cmp  = (ONE_DUTY_PCT * int'(span)) / 100;
                zero_cmp = (ZERO_DUTY_PCT * int'(span)) / 100;
                // red-green-blue text goes out green first
                grb = {green_byte, red_byte, pair_byte};
                for (int k = 0; k < GRB_W; k++) begin
                    slot.compare_value = grb[GRB_W-1-k] ? CMP_W'(one_cmp) : CMP_W'(zero_cmp);
                    slot.led_index     = LED_IDX_W'(led_count);
                    slot.last          = (k == GRB_W - 1);
                    bit_slot_q.push_back(slot);
                end
                led_count = (led_count + 1 >= LEDS_PER_FRAME) ? 0 : led_count + 1;
                group_pos = '0;
            end
        end
    endtask

    function automatic logic [CHAR_W-1:0] random_char();
        if ($urandom_range(0, 99) < 85)
            return CHAR_W'(hex_text[$urandom_range(0, 15)]);
        return CHAR_W'($urandom_range(0, 255));
    endfunction

    // sender: bursts of random length with random gaps
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                encode_char(s_tdata);
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (char_q.size() > 0) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= char_q.pop_front();
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 30);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: checks each beat and stalls on a changing pattern
    always @(posedge aclk) begin
        bit_slot_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (bit_slot_q.size() == 0) begin
                $error("unexpected beat: compare_value %0d led_index %0d",
                       m_tdata[CMP_W-1:0], m_tdata[CMP_W +: LED_IDX_W]);
                mismatches++;
            end else begin
                want = bit_slot_q.pop_front();
                if (m_tdata[CMP_W-1:0] !== want.compare_value) begin
                    $error("compare_value: expected %0d, actual %0d",
                           want.compare_value, m_tdata[CMP_W-1:0]);
                    mismatches++;
                end
                if (m_tdata[CMP_W +: LED_IDX_W] !== want.led_index) begin
                    $error("led_index: expected %0d, actual %0d",
                           want.led_index, m_tdata[CMP_W +: LED_IDX_W]);
                    mismatches++;
                end
                if (m_tlast !== want.last) begin
                    $error("last: expected %0b, actual %0b", want.last, m_tlast);
                    mismatches++;
                end
            end
        end
        stall_tick++;
        if (stall_tick % 97 == 0)
            stall_mode = stall_mode_t'($urandom_range(0, 3));
        case (stall_mode)
            READY_ALWAYS:      m_tready <= 1'b1;
            READY_RANDOM:      m_tready <= 1'($urandom_range(0, 1));
            READY_ONE_IN_FOUR: m_tready <= (stall_tick % 4 == 0);
            default:           m_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // wait until every character is taken and every expected beat has arrived
    task automatic wait_drained();
        do
            @(negedge aclk);
        while (char_q.size() != 0 || s_tvalid || bit_slot_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_period(input logic [PERIOD_W-1:0] value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge aclk);
        while (!cfg_ready);
        cfg_valid    <= 1'b0;
        timer_period = value;
    endtask

    initial begin
        logic [CHAR_W-1:0]   directed_chars[24];
        logic [PERIOD_W-1:0] phase_periods[7];
        directed_chars = '{
            8'h30, 8'h30, 8'h30, 8'h30, 8'h30, 8'h30,   // all zero bits
            8'h46, 8'h46, 8'h46, 8'h46, 8'h46, 8'h46,   // all one bits
            8'h00, 8'hFF, 8'h40, 8'h80, 8'h7F, 8'h01,   // non-hex extremes
            8'h61, 8'h66, 8'h39, 8'h41, 8'h47, 8'h5A    // lower case, boundary digits and past 'F'
        };
        phase_periods = '{16'hFFFF, 16'h0000, 16'h0001, 16'h0002, 16'd101,
                          PERIOD_W'($urandom_range(3, 65534)),
                          PERIOD_W'($urandom_range(3, 1000))};
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // directed beats at the reset period
        foreach (directed_chars[i])
            char_q.push_back(directed_chars[i]);
        wait_drained();

        foreach (phase_periods[p]) begin
            write_period(phase_periods[p]);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                char_q.push_back(random_char());
            wait_drained();
        end

        repeat (20) @(posedge aclk);
        if (mismatches == 0 && bit_slot_q.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
